// ----- hw/rtl/nns_pkg.sv -----
// Shared types, constants and helpers for the nearest node search block.
// Used by the search cells, the tail reducer and the top level; no dependencies.
package nns_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int COORD_WIDTH = 16;

  // Nodes are interleaved across the cells: node i sits in cell i % NUM_CELLS.
  localparam int NUM_CELLS = 8;
  localparam int CELL_W    = $clog2(NUM_CELLS);
  localparam int BANK_D    = (MAX_NODES + NUM_CELLS - 1) / NUM_CELLS;
  localparam int ADDR_W    = (BANK_D > 1) ? $clog2(BANK_D) : 1;
  localparam int NIDX_W    = ADDR_W + CELL_W;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CMP_W     = CNT_W + NIDX_W;

  localparam int IN_COORD_W = 16;
  localparam int OUT_IDX_W  = 10;
  localparam int DIST_W     = 34;
  localparam int STAT_W     = 2;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 3 * IN_COORD_W;
  localparam int OUT_BODY_W = OUT_IDX_W + DIST_W;
  localparam int OUT_DATA_W = ((OUT_BODY_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BODY_W;

  localparam int SQ_W  = 2 * COORD_WIDTH;
  localparam int SUM_W = SQ_W + 2;
  localparam int SAT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [DIST_W-1:0]             dist_t;
  typedef logic [NIDX_W-1:0]             nidx_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [CELL_W-1:0]             cell_id_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef logic [SUM_W-1:0]              sum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;

  // Scan token: one bank row plus the best candidate seen so far in that row.
  typedef struct packed {
    logic  vld;
    logic  last;
    addr_t addr;
    logic  best_vld;
    dist_t best_d;
    nidx_t best_idx;
  } tok_t;

  typedef struct packed {
    logic     en;
    cell_id_t bank;
    addr_t    addr;
    pos_t     pos;
  } wr_t;

  typedef struct packed {
    logic  vld;
    dist_t d;
    nidx_t idx;
  } best_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    dist_t                dsq;
    logic [STAT_W-1:0]    status;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } sched_state_t;

  function automatic coord_t to_coord(logic signed [IN_COORD_W-1:0] v);
    return coord_t'(v);
  endfunction

  function automatic dist_t sat_dist(sum_t s);
    logic [SAT_W-1:0] w;
    w = SAT_W'(s);
    if (w > SAT_W'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return DIST_W'(w);
  endfunction

endpackage

// ----- hw/rtl/nns_cell.sv -----
// One search cell: a bank of node positions and a three-stage distance unit.
// Depends on nns_pkg; tokens enter from the previous cell and leave to the next.
module nns_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  nns_pkg::cell_id_t cell_id,
  input  nns_pkg::cnt_t     node_cnt,
  input  nns_pkg::pos_t     qpt,
  input  nns_pkg::wr_t      wr,
  input  nns_pkg::tok_t     tok_in,
  output nns_pkg::tok_t     tok_out
);
  import nns_pkg::*;

  pos_t  mem [BANK_D];
  pos_t  rd_r;
  tok_t  s1_tok_r, s2_tok_r, s3_tok_r;
  logic  s1_nv_r, s2_nv_r;
  sq_t   sqx_r, sqy_r, sqz_r;
  nidx_t my_idx;
  logic  node_vld;

  logic signed [COORD_WIDTH:0] dx, dy, dz;
  logic [COORD_WIDTH-1:0]      mx, my, mz;
  sum_t  sum;
  dist_t dsq;
  tok_t  s3_tok_nxt;

  always_ff @(posedge clk) begin
    if (wr.en && wr.bank == cell_id) begin
      mem[wr.addr] <= wr.pos;
    end
    rd_r <= mem[tok_in.addr];
  end

  assign my_idx   = {tok_in.addr, cell_id};
  assign node_vld = CMP_W'(my_idx) < CMP_W'(node_cnt);

  // Stage 2: per-axis magnitudes and squares.
  always_comb begin
    dx = (COORD_WIDTH+1)'(rd_r.x) - (COORD_WIDTH+1)'(qpt.x);
    dy = (COORD_WIDTH+1)'(rd_r.y) - (COORD_WIDTH+1)'(qpt.y);
    dz = (COORD_WIDTH+1)'(rd_r.z) - (COORD_WIDTH+1)'(qpt.z);
    mx = dx[COORD_WIDTH] ? COORD_WIDTH'(-dx) : COORD_WIDTH'(dx);
    my = dy[COORD_WIDTH] ? COORD_WIDTH'(-dy) : COORD_WIDTH'(dy);
    mz = dz[COORD_WIDTH] ? COORD_WIDTH'(-dz) : COORD_WIDTH'(dz);
  end

  // Stage 3: sum, saturate, keep the earlier candidate on a tie.
  always_comb begin
    sum  = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
    dsq  = sat_dist(sum);
    s3_tok_nxt = s2_tok_r;
    if (s2_nv_r && (!s2_tok_r.best_vld || dsq < s2_tok_r.best_d)) begin
      s3_tok_nxt.best_vld = 1'b1;
      s3_tok_nxt.best_d   = dsq;
      s3_tok_nxt.best_idx = {s2_tok_r.addr, cell_id};
    end
  end

  always_ff @(posedge clk) begin
    sqx_r <= SQ_W'(mx) * SQ_W'(mx);
    sqy_r <= SQ_W'(my) * SQ_W'(my);
    sqz_r <= SQ_W'(mz) * SQ_W'(mz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r <= '0;
      s2_tok_r <= '0;
      s3_tok_r <= '0;
      s1_nv_r  <= 1'b0;
      s2_nv_r  <= 1'b0;
    end else begin
      s1_tok_r <= tok_in;
      s1_nv_r  <= node_vld;
      s2_tok_r <= s1_tok_r;
      s2_nv_r  <= s1_nv_r;
      s3_tok_r <= s3_tok_nxt;
    end
  end

  assign tok_out = s3_tok_r;

endmodule

// ----- hw/rtl/nns_reduce.sv -----
// Tail reducer: folds the per-row winners leaving the last cell into one result.
// Depends on nns_pkg; the output is the updated best including this cycle's row.
module nns_reduce (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clr,
  input  nns_pkg::tok_t  tail,
  output nns_pkg::best_t best
);
  import nns_pkg::*;

  best_t acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (clr) begin
      acc_nxt.vld = 1'b0;
    end else if (tail.vld && tail.best_vld && (!acc_r.vld || tail.best_d < acc_r.d)) begin
      acc_nxt.vld = 1'b1;
      acc_nxt.d   = tail.best_d;
      acc_nxt.idx = tail.best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign best = acc_nxt;

endmodule

// ----- hw/rtl/nearest_node_search_3d.sv -----
// Top level of the nearest node search: request scheduler, cell chain, output skid.
// Depends on nns_pkg, nns_cell and nns_reduce.
//
// Brute-force 3D nearest node search over a store of up to 1024 Q8.8 positions.
// Clear, append and unused request codes are answered without a scan. The store
// is split over a chain of 8 cells, each bank gives one node per cycle, and a
// row token crosses the chain through three register stages per cell before the
// tail reducer folds it in. Ties go to the lower node index. A query on an empty
// store answers at once with the empty status; an append to a full store is
// dropped and flagged. Reset clears the node count but not the stored positions;
// positions are valid once appended.
module nearest_node_search_3d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // coord_x[15:0], coord_y[31:16], coord_z[47:32]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // node_index[9:0], dist_squared[43:10], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);
  import nns_pkg::*;

  sched_state_t state_r, state_nxt;
  cnt_t         cnt_r, cnt_nxt;
  addr_t        seq_addr_r, seq_addr_nxt;
  addr_t        last_row_r, last_row_nxt;
  pos_t         qpt_r, in_pos;
  logic         in_acc, is_query, start_scan, full, last_issue, tail_done;
  logic         push, take;
  res_t         res, out_r, pend_r, out_nxt, pend_nxt;
  logic         out_vld_r, pend_vld_r, out_vld_nxt, pend_vld_nxt;
  wr_t          wr;
  tok_t         head_tok;
  tok_t         chain [NUM_CELLS+1];
  best_t        best;

  assign in_tready  = (state_r == ST_IDLE) && !pend_vld_r;
  assign in_acc     = in_tvalid && in_tready;
  assign is_query   = in_tuser == REQ_QUERY;
  assign full       = cnt_r >= CNT_W'(MAX_NODES);
  assign start_scan = in_acc && is_query && (cnt_r != '0);
  assign last_issue = seq_addr_r == last_row_r;
  assign tail_done  = chain[NUM_CELLS].vld && chain[NUM_CELLS].last;

  assign in_pos.x = to_coord(in_tdata[15:0]);
  assign in_pos.y = to_coord(in_tdata[31:16]);
  assign in_pos.z = to_coord(in_tdata[47:32]);

  always_comb begin
    wr.en   = in_acc && (in_tuser == REQ_APPEND) && !full;
    wr.bank = cnt_r[CELL_W-1:0];
    wr.addr = ADDR_W'(cnt_r >> CELL_W);
    wr.pos  = in_pos;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start_scan) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_issue) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (tail_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scheduler outputs: row tokens, store updates, results
  always_comb begin
    head_tok          = '0;
    cnt_nxt           = cnt_r;
    seq_addr_nxt      = seq_addr_r;
    last_row_nxt      = last_row_r;
    push              = 1'b0;
    res               = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_CLEAR: begin
              cnt_nxt = '0;
              push    = 1'b1;
            end
            REQ_APPEND: begin
              push = 1'b1;
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                res.idx = OUT_IDX_W'(cnt_r);
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            REQ_QUERY: begin
              if (cnt_r == '0) begin
                push       = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                seq_addr_nxt = '0;
                last_row_nxt = ADDR_W'((cnt_r - 1'b1) >> CELL_W);
              end
            end
            default: push = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        head_tok.vld  = 1'b1;
        head_tok.last = last_issue;
        head_tok.addr = seq_addr_r;
        seq_addr_nxt  = seq_addr_r + 1'b1;
      end
      ST_DRAIN: begin
        if (tail_done) begin
          push     = 1'b1;
          res.idx  = OUT_IDX_W'(best.idx);
          res.dsq  = best.d;
        end
      end
      default: ;
    endcase
  end

  assign chain[0] = head_tok;

  always_ff @(posedge clk) begin
    if (start_scan) begin
      qpt_r <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      seq_addr_r <= '0;
      last_row_r <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      seq_addr_r <= seq_addr_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    nns_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_id  (CELL_W'(g)),
      .node_cnt (cnt_r),
      .qpt      (qpt_r),
      .wr       (wr),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  nns_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (start_scan),
    .tail  (chain[NUM_CELLS]),
    .best  (best)
  );

  // Output register with one word of skid behind it.
  assign take = out_vld_r && out_tready;

  always_comb begin
    out_nxt      = out_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r;
    pend_vld_nxt = pend_vld_r;
    if (push) begin
      if (!out_vld_r || take) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        pend_nxt     = res;
        pend_vld_nxt = 1'b1;
      end
    end else if (take) begin
      if (pend_vld_r) begin
        out_nxt      = pend_r;
        pend_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_r.dsq, out_r.idx};
  assign out_tuser  = out_r.status;

  a_push_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !pend_vld_r)
    else $error("result pushed while skid word still pending");

  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> out_vld_r)
    else $error("skid word held with output register empty");

  a_tail_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    tail_done |-> state_r == ST_DRAIN)
    else $error("last row token left the chain outside drain");

  a_query_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && tail_done) |-> best.vld)
    else $error("query finished without a candidate");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NODES))
    else $error("node count beyond store depth");

endmodule
